>>> hdl/vrp_pkg.sv
// shared types and constants for vertex_rotate_project
// no dependencies; imported by every module of the block
`default_nettype none
package vrp_pkg;

	localparam int COORD_BITS      = 12;
	localparam int ANGLE_BITS_DEF  = 16;
	localparam int SINE_DEPTH_DEF  = 256;
	localparam int TRIG_FRAC_DEF   = 14;
	localparam int STEP_BITS       = 16;
	localparam int DIST_BITS       = 12;
	localparam int CENTER_BITS     = 10;
	localparam int SCREEN_BITS     = 16;
	localparam int PROJ_SHIFT      = 8;
	localparam int NUM_BITS        = DIST_BITS + PROJ_SHIFT;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 16;

	localparam logic [STEP_BITS-1:0]   STEP_X_RST = 16'd522;
	localparam logic [STEP_BITS-1:0]   STEP_Y_RST = 16'd417;
	localparam logic [DIST_BITS-1:0]   DIST_RST   = 12'd150;
	localparam logic [DIST_BITS-1:0]   MIN_D_RST  = 12'd20;
	localparam logic [CENTER_BITS-1:0] CX_RST     = 10'd160;
	localparam logic [CENTER_BITS-1:0] CY_RST     = 10'd110;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_STEP_X   = 3'd0,
		REG_STEP_Y   = 3'd1,
		REG_DISTANCE = 3'd2,
		REG_MIN_DEPTH = 3'd3,
		REG_CENTER_X = 3'd4,
		REG_CENTER_Y = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIG,
		ST_MUL,
		ST_ACC,
		ST_DEN,
		ST_DIV,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic signed [COORD_BITS-1:0] vertex_z;
		logic                         new_frame;
	} vtx_t;

	typedef struct packed {
		logic signed [SCREEN_BITS-1:0] screen_x;
		logic signed [SCREEN_BITS-1:0] screen_y;
		logic                          saturated;
	} pix_t;

endpackage
`default_nettype wire

>>> hdl/vrp_sincos.sv
// quarter-wave sine lookup: phase in, signed q1.f sine out
// depends on vrp_pkg for the table constants
`default_nettype none
module vrp_sincos import vrp_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int DEPTH      = SINE_DEPTH_DEF,
	parameter int FRAC       = TRIG_FRAC_DEF
) (
	input  wire logic [ANGLE_BITS-1:0]  phase,
	output logic signed [FRAC+1:0]      sine
);

	localparam int QB = ANGLE_BITS - 2;
	localparam int IW = $clog2(DEPTH + 1);

	logic [FRAC:0]       tab [DEPTH+1];
	logic [1:0]          quad;
	logic [QB+IW-1:0]    scaled;
	logic [IW-1:0]       idx;
	logic [IW-1:0]       sel;
	logic signed [FRAC+1:0] mag;

	for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
		// q30 taylor series of sin, terms truncated, clamped at zero
		localparam longint unsigned A  = (HALF_PI_Q30 * k) / DEPTH;
		localparam longint unsigned T1 = ((((A * A) >> 30) * A) >> 30) / 6;
		localparam longint unsigned T2 = ((((T1 * A) >> 30) * A) >> 30) / 20;
		localparam longint unsigned T3 = ((((T2 * A) >> 30) * A) >> 30) / 42;
		localparam longint unsigned T4 = ((((T3 * A) >> 30) * A) >> 30) / 72;
		localparam longint unsigned T5 = ((((T4 * A) >> 30) * A) >> 30) / 110;
		localparam longint unsigned T6 = ((((T5 * A) >> 30) * A) >> 30) / 156;
		localparam longint unsigned T7 = ((((T6 * A) >> 30) * A) >> 30) / 210;
		localparam longint SUM = longint'(A) - longint'(T1) + longint'(T2) - longint'(T3)
			+ longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
		localparam longint unsigned S = (SUM < 0) ? 64'd0 : 64'(SUM);
		localparam longint unsigned R = (S + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
		assign tab[k] = R[FRAC:0];
	end

	always_comb begin
		quad   = phase[ANGLE_BITS-1 -: 2];
		scaled = (QB+IW)'(phase[QB-1:0]) * (QB+IW)'(DEPTH);
		idx    = scaled[QB+IW-1:QB];
		sel    = quad[0] ? (IW'(DEPTH) - idx) : idx;
		mag    = $signed({1'b0, tab[sel]});
		sine   = quad[1] ? -mag : mag;
	end

endmodule
`default_nettype wire

>>> hdl/vrp_div.sv
// restoring divider, one quotient bit per cycle
// depends on vrp_pkg for the numerator width
`default_nettype none
module vrp_div import vrp_pkg::*; #(
	parameter int DENW = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NUM_BITS-1:0] num,
	input  wire logic [DENW-1:0]     den,
	output logic                     done,
	output logic [NUM_BITS-1:0]      quot
);

	localparam int CW = $clog2(NUM_BITS + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [DENW:0]   rem_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DENW-1:0] den_q;
	logic [DENW:0]   rem_sh;
	logic            fits;

	always_comb begin
		rem_sh = {rem_q[DENW-1:0], quo_q[NUM_BITS-1]};
		fits   = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

>>> hdl/vertex_rotate_project.sv
// Rotates each vertex about x then y and projects it in perspective. One request
// goes through these steps in order: it is taken, 4 table reads give the cosines and
// sines, 8 multiply and accumulate steps run on the one shared multiplier, the depth is
// clamped, the serial divider works out the scale, the two screen products are formed on
// the same multiplier and the output register is loaded. A new request is taken once the
// previous result has moved to the output register, even if that result has not yet
// been taken.
// depends on vrp_pkg, vrp_sincos, vrp_div
`default_nettype none
module vertex_rotate_project import vrp_pkg::*; #(
	parameter int ANGLE_BITS         = ANGLE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH   = SINE_DEPTH_DEF,
	parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     vtx_valid,
	output logic                          vtx_ready,
	input  wire vtx_t                     vtx,
	output logic                          pix_valid,
	input  wire logic                     pix_ready,
	output pix_t                          pix,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int F     = TRIG_FRACTION_BITS;
	localparam int QB    = ANGLE_BITS - 2;
	localparam int OPW   = COORD_BITS + 2;
	localparam int TW    = F + 2;
	localparam int BW    = (TW > NUM_BITS + 1) ? TW : NUM_BITS + 1;
	localparam int PRODW = OPW + BW;
	localparam int ACCW  = PRODW + 1;
	localparam int DENW  = ((OPW > DIST_BITS) ? OPW : DIST_BITS) + 1;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << QB;

	seq_state_t state_q, state_d;

	logic [STEP_BITS-1:0]   step_x_q, step_y_q;
	logic [DIST_BITS-1:0]   dist_q, min_d_q;
	logic [CENTER_BITS-1:0] cen_x_q, cen_y_q;
	logic [ANGLE_BITS-1:0]  angle_x_q, angle_y_q;

	logic signed [COORD_BITS-1:0] x_q, y_q, z_q;
	logic signed [OPW-1:0]  y1_q, z1_q, x2_q, z2_q;
	logic signed [TW-1:0]   cx_q, sx_q, cy_q, sy_q;
	logic [NUM_BITS-1:0]    scale_q;
	logic signed [PRODW-1:0] prod_s1;
	logic signed [ACCW-1:0] acc_q;
	logic [1:0]             trig_q;
	logic [3:0]             op_q;
	logic                   sat_q;
	pix_t                   pix_q;
	logic                   pix_valid_q;
	logic signed [SCREEN_BITS-1:0] px_q;
	logic signed [SCREEN_BITS-1:0] py_q;

	logic                   take;
	logic                   div_start;
	logic                   div_done;
	logic [NUM_BITS-1:0]    div_quot;
	logic [ANGLE_BITS-1:0]  trig_phase;
	logic signed [TW-1:0]   trig_val;
	logic signed [OPW-1:0]  mul_a;
	logic signed [BW-1:0]   mul_b;
	logic signed [ACCW-1:0] acc_n;
	logic signed [ACCW-1:0] rot_t;
	logic signed [ACCW-1:0] proj_t;
	logic signed [ACCW:0]   proj_c;
	logic signed [SCREEN_BITS-1:0] proj_sat;
	logic                   proj_clip;
	logic signed [DENW:0]   dsum;
	logic [DENW-1:0]        dmin;
	logic [DENW-1:0]        den;

	assign take      = vtx_valid && vtx_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q <= STEP_X_RST;
			step_y_q <= STEP_Y_RST;
			dist_q   <= DIST_RST;
			min_d_q  <= MIN_D_RST;
			cen_x_q  <= CX_RST;
			cen_y_q  <= CY_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_STEP_X:    step_x_q <= cfg_data;
				REG_STEP_Y:    step_y_q <= cfg_data;
				REG_DISTANCE:  dist_q   <= cfg_data[DIST_BITS-1:0];
				REG_MIN_DEPTH: min_d_q  <= cfg_data[DIST_BITS-1:0];
				REG_CENTER_X:  cen_x_q  <= cfg_data[CENTER_BITS-1:0];
				REG_CENTER_Y:  cen_y_q  <= cfg_data[CENTER_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (trig_q)
			2'd0:    trig_phase = angle_x_q + QUARTER;
			2'd1:    trig_phase = angle_x_q;
			2'd2:    trig_phase = angle_y_q + QUARTER;
			default: trig_phase = angle_y_q;
		endcase
	end

	vrp_sincos #(
		.ANGLE_BITS(ANGLE_BITS),
		.DEPTH     (SINE_TABLE_DEPTH),
		.FRAC      (F)
	) u_sincos (
		.phase(trig_phase),
		.sine (trig_val)
	);

	// operand selection for the shared multiplier
	always_comb begin
		case (op_q)
			4'd0:    begin mul_a = OPW'(y_q); mul_b = BW'(cx_q); end
			4'd1:    begin mul_a = OPW'(z_q); mul_b = BW'(sx_q); end
			4'd2:    begin mul_a = OPW'(y_q); mul_b = BW'(sx_q); end
			4'd3:    begin mul_a = OPW'(z_q); mul_b = BW'(cx_q); end
			4'd4:    begin mul_a = OPW'(x_q); mul_b = BW'(cy_q); end
			4'd5:    begin mul_a = z1_q;      mul_b = BW'(sy_q); end
			4'd6:    begin mul_a = z1_q;      mul_b = BW'(cy_q); end
			4'd7:    begin mul_a = OPW'(x_q); mul_b = BW'(sy_q); end
			4'd8:    begin mul_a = x2_q; mul_b = BW'($signed({1'b0, scale_q})); end
			default: begin mul_a = y1_q; mul_b = BW'($signed({1'b0, scale_q})); end
		endcase
	end

	always_comb begin
		case (op_q)
			4'd1, 4'd7: acc_n = acc_q - ACCW'(prod_s1);
			4'd3, 4'd5: acc_n = acc_q + ACCW'(prod_s1);
			default:    acc_n = ACCW'(prod_s1);
		endcase
		// shifts truncate toward zero
		rot_t  = (acc_n < 0)
			? ((acc_n + $signed({{(ACCW-F){1'b0}}, {F{1'b1}}})) >>> F)
			: (acc_n >>> F);
		proj_t = (acc_n < 0)
			? ((acc_n + $signed({{(ACCW-PROJ_SHIFT){1'b0}}, {PROJ_SHIFT{1'b1}}})) >>> PROJ_SHIFT)
			: (acc_n >>> PROJ_SHIFT);
		proj_c = (ACCW+1)'(proj_t) + $signed({1'b0, (op_q == 4'd8) ? cen_x_q : cen_y_q});
		if (proj_c > (ACCW+1)'(32767)) begin
			proj_sat  = 16'sh7fff;
			proj_clip = 1'b1;
		end else if (proj_c < -(ACCW+1)'(32768)) begin
			proj_sat  = -16'sh8000;
			proj_clip = 1'b1;
		end else begin
			proj_sat  = proj_c[SCREEN_BITS-1:0];
			proj_clip = 1'b0;
		end
	end

	// depth clamp, zero min depth counts as one
	always_comb begin
		dsum = (DENW+1)'(z2_q) + $signed({1'b0, DENW'(dist_q)});
		dmin = (min_d_q == '0) ? DENW'(1) : DENW'(min_d_q);
		den  = (dsum < $signed({1'b0, dmin})) ? dmin : dsum[DENW-1:0];
	end

	vrp_div #(
		.DENW(DENW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({dist_q, {PROJ_SHIFT{1'b0}}}),
		.den   (den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		vtx_ready = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				vtx_ready = 1'b1;
				if (vtx_valid)
					state_d = ST_TRIG;
			end
			ST_TRIG: begin
				if (trig_q == 2'd3)
					state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				if (op_q == 4'd7)
					state_d = ST_DEN;
				else if (op_q == 4'd9)
					state_d = ST_DONE;
				else
					state_d = ST_MUL;
			end
			ST_DEN: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_MUL;
			end
			ST_DONE: begin
				if (!pix_valid_q || pix_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_x_q   <= '0;
			angle_y_q   <= '0;
			trig_q      <= '0;
			op_q        <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			if (take) begin
				trig_q <= '0;
				op_q   <= '0;
				if (vtx.new_frame) begin
					angle_x_q <= angle_x_q + ANGLE_BITS'(step_x_q);
					angle_y_q <= angle_y_q + ANGLE_BITS'(step_y_q);
				end
			end
			if (state_q == ST_TRIG)
				trig_q <= trig_q + 1'b1;
			if (state_q == ST_ACC && op_q != 4'd9)
				op_q <= op_q + 1'b1;
			if (state_q == ST_DONE && (!pix_valid_q || pix_ready))
				pix_valid_q <= 1'b1;
			else if (pix_ready)
				pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_q <= vtx.vertex_x;
			y_q <= vtx.vertex_y;
			z_q <= vtx.vertex_z;
		end
		if (state_q == ST_TRIG) begin
			case (trig_q)
				2'd0:    cx_q <= trig_val;
				2'd1:    sx_q <= trig_val;
				2'd2:    cy_q <= trig_val;
				default: sy_q <= trig_val;
			endcase
		end
		if (state_q == ST_MUL)
			prod_s1 <= mul_a * mul_b;
		if (state_q == ST_ACC) begin
			acc_q <= acc_n;
			case (op_q)
				4'd1:    y1_q <= rot_t[OPW-1:0];
				4'd3:    z1_q <= rot_t[OPW-1:0];
				4'd5:    x2_q <= rot_t[OPW-1:0];
				4'd7:    z2_q <= rot_t[OPW-1:0];
				4'd8: begin
					px_q  <= proj_sat;
					sat_q <= proj_clip;
				end
				4'd9: begin
					py_q  <= proj_sat;
					sat_q <= sat_q | proj_clip;
				end
				default: ;
			endcase
		end
		if (state_q == ST_DIV && div_done)
			scale_q <= div_quot;
		// output register only changes once the previous result has gone
		if (state_q == ST_DONE && (!pix_valid_q || pix_ready)) begin
			pix_q.screen_x  <= px_q;
			pix_q.screen_y  <= py_q;
			pix_q.saturated <= sat_q;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

`ifndef NO_ASSERTIONS
	a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its wait state");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !vtx_ready)
		else $error("request taken while previous one still in work");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without finishing the sequence");
`endif

endmodule
`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for vertex_rotate_project: directed corners, register sweeps
// and random vertices against a local bit-accurate predictor of rotation and projection
// depends on vrp_pkg and the vertex_rotate_project rtl
`default_nettype none
module tb;
	import vrp_pkg::*;

	localparam int QBITS = 14;
	localparam int FRAC = 14;
	localparam int DEPTH = 256;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n;
	logic vtx_valid, vtx_ready, pix_valid, pix_ready, cfg_valid, cfg_ready;
	vtx_t vtx;
	pix_t pix;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	vertex_rotate_project dut (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .vtx(vtx),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	longint sine_rom [0:DEPTH];
	logic [15:0] phase_step_x, phase_step_y, phase_x, phase_y;
	logic [11:0] view_dist, depth_floor;
	logic [9:0] offset_x, offset_y;
	pix_t pending_pixels [$];

	int mismatches = 0;
	int vertices_sent = 0;
	int pixels_seen = 0;
	int clamped_seen = 0;
	int reg_writes = 0;
	int idle_cycles = 0;
	logic hold_req = 1'b0;

	function automatic longint taylor_sine(longint unsigned a);
		longint unsigned t;
		longint acc;
		t = a;
		acc = longint'(a);
		for (int k = 1; k <= 7; k++) begin
			t = (t * a) >> 30;
			t = (t * a) >> 30;
			t = t / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) acc = acc - longint'(t);
			else acc = acc + longint'(t);
		end
		return (acc < 0) ? 0 : acc;
	endfunction

	function automatic longint sine_at(logic [15:0] ph);
		logic [1:0] quad;
		longint idx, mag;
		quad = ph[15:14];
		idx = (longint'(ph[13:0]) * DEPTH) >> QBITS;
		mag = quad[0] ? sine_rom[DEPTH - idx] : sine_rom[idx];
		return quad[1] ? -mag : mag;
	endfunction

	function automatic longint sat_screen(longint v, ref bit clipped);
		if (v > 32767) begin
			clipped = 1'b1;
			return 32767;
		end
		if (v < -32768) begin
			clipped = 1'b1;
			return -32768;
		end
		return v;
	endfunction

	function automatic pix_t project_vertex(vtx_t v);
		longint x, y, z, cx, sx, cy, sy, y1, z1, x2, z2, d, m, sc, px, py;
		bit clipped;
		pix_t r;
		clipped = 1'b0;
		if (v.new_frame) begin
			phase_x = phase_x + phase_step_x;
			phase_y = phase_y + phase_step_y;
		end
		x = v.vertex_x;
		y = v.vertex_y;
		z = v.vertex_z;
		cx = sine_at(phase_x + 16'h4000);
		sx = sine_at(phase_x);
		cy = sine_at(phase_y + 16'h4000);
		sy = sine_at(phase_y);
		y1 = (y * cx - z * sx) / (64'sd1 << FRAC);
		z1 = (y * sx + z * cx) / (64'sd1 << FRAC);
		x2 = (x * cy + z1 * sy) / (64'sd1 << FRAC);
		z2 = (z1 * cy - x * sy) / (64'sd1 << FRAC);
		m = (depth_floor == 0) ? 1 : longint'(depth_floor);
		d = z2 + longint'(view_dist);
		if (d < m) d = m;
		sc = (longint'(view_dist) << 8) / d;
		px = (x2 * sc) / 256 + longint'(offset_x);
		py = (y1 * sc) / 256 + longint'(offset_y);
		px = sat_screen(px, clipped);
		py = sat_screen(py, clipped);
		r.screen_x = px[15:0];
		r.screen_y = py[15:0];
		r.saturated = clipped;
		return r;
	endfunction

	task automatic send_vertex(vtx_t v);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx <= v;
		vtx_valid <= 1'b1;
		@(negedge clk);
		while (!vtx_ready) @(negedge clk);
		@(posedge clk);
		pending_pixels.push_back(project_vertex(v));
		vertices_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
		case (idx)
			REG_STEP_X: phase_step_x = val;
			REG_STEP_Y: phase_step_y = val;
			REG_DISTANCE: view_dist = val[11:0];
			REG_MIN_DEPTH: depth_floor = val[11:0];
			REG_CENTER_X: offset_x = val[9:0];
			REG_CENTER_Y: offset_y = val[9:0];
			default: ;
		endcase
	endtask

	// wait for every outstanding request to come back before touching registers
	task automatic quiesce();
		vtx_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs(logic [15:0] sx, logic [15:0] sy, logic [15:0] vdist,
			logic [15:0] mind, logic [15:0] ox, logic [15:0] oy);
		quiesce();
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
		write_reg(REG_DISTANCE, vdist);
		write_reg(REG_MIN_DEPTH, mind);
		write_reg(REG_CENTER_X, ox);
		write_reg(REG_CENTER_Y, oy);
	endtask

	function automatic vtx_t make_vtx(int x, int y, int z, bit nf);
		vtx_t v;
		v.vertex_x = x[11:0];
		v.vertex_y = y[11:0];
		v.vertex_z = z[11:0];
		v.new_frame = nf;
		return v;
	endfunction

	function automatic logic [11:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 12'h800;
			1: return 12'h7ff;
			2: return 12'($urandom_range(0, 15)) - 12'd8;
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic vtx_t rand_vtx();
		vtx_t v;
		v.vertex_x = rand_coord();
		v.vertex_y = rand_coord();
		v.vertex_z = rand_coord();
		v.new_frame = ($urandom_range(0, 7) == 0);
		return v;
	endfunction

	task automatic test_reset_defaults();
		send_vertex(make_vtx(0, 0, 0, 0));
		send_vertex(make_vtx(2047, 2047, 2047, 0));
		send_vertex(make_vtx(-2048, -2048, -2048, 0));
		send_vertex(make_vtx(100, -50, 30, 1));
		send_vertex(make_vtx(-2048, 2047, -2048, 1));
	endtask

	task automatic test_corner_registers();
		// largest view distance with a depth floor of one, no angle step, full-scale corner vertices
		load_regs(16'd0, 16'd0, 16'd4095, 16'd1, 16'd1023, 16'd0);
		send_vertex(make_vtx(2047, -2048, -2048, 0));
		send_vertex(make_vtx(-2048, 2047, -2048, 1));
		send_vertex(make_vtx(2047, 2047, 2047, 0));
		// zero floor is treated as one
		load_regs(16'hffff, 16'hffff, 16'd1, 16'd0, 16'd0, 16'd1023);
		send_vertex(make_vtx(5, 5, -2048, 1));
		send_vertex(make_vtx(-2048, -2048, 2047, 1));
		// zero distance gives the centres back
		load_regs(16'h4000, 16'h8000, 16'd0, 16'd4095, 16'd512, 16'd300);
		send_vertex(make_vtx(2047, 2047, 2047, 1));
		send_vertex(make_vtx(-2048, 1, -7, 1));
		// upper data bits must be dropped, unused indexes ignored
		load_regs(16'h0001, 16'h7fff, 16'hf096, 16'hf014, 16'hfca0, 16'hfc6e);
		write_reg(3'd6, 16'hffff);
		write_reg(3'd7, 16'h1234);
		for (int i = 0; i < 6; i++) send_vertex(make_vtx(-2048 + i * 800, 2047 - i * 700,
			i * 600 - 2048, 1));
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0)
				load_regs(16'd522, 16'd417, 16'd150, 16'd20, 16'd160, 16'd110);
			else
				load_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4095)),
					16'($urandom_range(0, 4095)), 16'($urandom), 16'($urandom));
			for (int i = 0; i < 225; i++) send_vertex(rand_vtx());
		end
	endtask

	task automatic test_output_stall();
		quiesce();
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++) send_vertex(rand_vtx());
	endtask

	// result side: random ready gaps, one long hold-off on request
	initial begin
		int w;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				pix_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				w = $urandom_range(0, 3);
				if (w > 0) begin
					pix_ready <= 1'b0;
					repeat (w) @(posedge clk);
				end
			end
			pix_ready <= 1'b1;
			@(negedge clk);
			while (!pix_valid) @(negedge clk);
			@(posedge clk);
			pixels_seen++;
			if (pix.saturated) clamped_seen++;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%0d y=%0d sat=%0b",
						pix.screen_x, pix.screen_y, pix.saturated);
			end else begin
				pix_t e;
				e = pending_pixels.pop_front();
				if (e !== pix) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
							e.screen_x, e.screen_y, e.saturated,
							pix.screen_x, pix.screen_y, pix.saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((vtx_valid && vtx_ready) || (pix_valid && pix_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("vertex_rotate_project regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		vtx_valid <= 1'b0;
		vtx <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		for (int k = 0; k <= DEPTH; k++)
			sine_rom[k] = (taylor_sine((HALF_PI_Q30 * k) / DEPTH) + (64'd1 << (29 - FRAC)))
				>> (30 - FRAC);
		phase_step_x = 16'd522;
		phase_step_y = 16'd417;
		view_dist = 12'd150;
		depth_floor = 12'd20;
		offset_x = 10'd160;
		offset_y = 10'd110;
		phase_x = '0;
		phase_y = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_corner_registers();
		test_random_phases();
		test_output_stall();
		quiesce();

		$display("covered %0d vertices, %0d results (%0d clamped), %0d register writes",
			vertices_sent, pixels_seen, clamped_seen, reg_writes);
		$display("including corner registers, long output stall and %0d mismatches", mismatches);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("vertex_rotate_project regression: pass");
		else
			$display("vertex_rotate_project regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
